// ===== src/hclp_pkg.sv =====
// Shared types, constants and helpers for the height command line parser.
// No dependencies.
`default_nettype none
package hclp_pkg;

  localparam int NUM_LINKS_DEF     = 2;
  localparam int LINE_CAPACITY_DEF = 32;
  localparam int KW_LEN            = 7;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_BLANKS = 3'd1,
    PH_SIGNED = 3'd2,
    PH_DIGITS = 3'd3,
    PH_BAD    = 3'd4
  } phase_t;

  // per-link parse state, all-zero is the fresh-line value
  typedef struct packed {
    phase_t      phase;
    logic [2:0]  pos;
    logic        neg;
    logic [31:0] mag;
    logic        ovf;
    logic        ended;
  } line_st_t;

  function automatic logic [7:0] keyword_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0: ch = 8'h48;  // H
      3'd1: ch = 8'h45;  // E
      3'd2: ch = 8'h49;  // I
      3'd3: ch = 8'h47;  // G
      3'd4: ch = 8'h48;  // H
      3'd5: ch = 8'h54;  // T
      3'd6: ch = 8'h3A;  // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== src/hclp_in_if.sv =====
// Request channel for received bytes: valid/ready plus byte and link tag.
// Depends on nothing.
`default_nettype none
interface hclp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       link_index;

  modport source (output valid, output rx_byte, output link_index, input ready);
  modport sink   (input valid, input rx_byte, input link_index, output ready);
endinterface
`default_nettype wire

// ===== src/hclp_out_if.sv =====
// Result channel for finished lines: valid/ready plus parse outcome.
// Depends on nothing.
`default_nettype none
interface hclp_out_if;
  logic               valid;
  logic               ready;
  logic               command_valid;
  logic signed [31:0] height_value;
  logic               line_link;
  logic [1:0]         last_valid_source;

  modport source (output valid, output command_valid, output height_value,
                  output line_link, output last_valid_source, input ready);
  modport sink   (input valid, input command_valid, input height_value,
                  input line_link, input last_valid_source, output ready);
endinterface
`default_nettype wire

// ===== src/hclp_line_step.sv =====
// Next-state logic for one byte of one link's line, plus the end-of-line verdict.
// Depends on hclp_pkg.
`default_nettype none
module hclp_line_step #(
  parameter int LINE_CAPACITY = hclp_pkg::LINE_CAPACITY_DEF,
  localparam int CW = $clog2(LINE_CAPACITY)
) (
  input  hclp_pkg::line_st_t cur_st,
  input  logic [CW-1:0]      cur_cnt,
  input  logic [7:0]         rx_byte,
  output hclp_pkg::line_st_t nxt_st,
  output logic [CW-1:0]      nxt_cnt,
  output logic               cmd_ok,
  output logic signed [31:0] cmd_value
);
  import hclp_pkg::*;

  localparam logic [CW-1:0] CNT_LAST = CW'(LINE_CAPACITY - 1);

  logic        digit;
  logic        blank;
  logic        sign;
  logic [35:0] acc_wide;
  logic [2:0]  pos_inc;

  assign digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign blank = (rx_byte == CH_SP) || (rx_byte == CH_TAB) ||
                 (rx_byte == CH_VT) || (rx_byte == CH_FF);
  assign sign  = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
  // m*10 + d; anything above bit 31 means the magnitude would wrap
  assign acc_wide = ({4'b0, cur_st.mag} << 3) + ({4'b0, cur_st.mag} << 1) +
                    36'(rx_byte[3:0]);
  assign pos_inc = cur_st.pos + 3'd1;

  always_comb begin
    nxt_st    = cur_st;
    nxt_cnt   = cur_cnt;
    cmd_ok    = 1'b0;
    cmd_value = '0;
    if (rx_byte == CH_LF) begin
      cmd_ok = (cur_st.phase == PH_DIGITS);
      if (cmd_ok) begin
        if (cur_st.neg) begin
          cmd_value = (cur_st.ovf || cur_st.mag > NEG_LIMIT) ? NEG_LIMIT
                                                              : 32'd0 - cur_st.mag;
        end else begin
          cmd_value = (cur_st.ovf || cur_st.mag > POS_LIMIT) ? POS_LIMIT : cur_st.mag;
        end
      end
      nxt_st  = '0;
      nxt_cnt = '0;
    end else if (cur_cnt < CNT_LAST) begin
      nxt_cnt = cur_cnt + CW'(1);
      if (!cur_st.ended) begin
        if (rx_byte == CH_NUL) begin
          nxt_st.ended = 1'b1;
        end else if (cur_st.phase == PH_PREFIX) begin
          if (cur_st.pos < 3'(KW_LEN) && rx_byte == keyword_char(cur_st.pos)) begin
            nxt_st.pos = pos_inc;
            if (pos_inc == 3'(KW_LEN)) begin
              nxt_st.phase = PH_BLANKS;
            end
          end else begin
            nxt_st.phase = PH_BAD;
          end
        end else if (cur_st.phase == PH_BLANKS && blank) begin
          nxt_st.phase = PH_BLANKS;
        end else if (cur_st.phase == PH_BLANKS && sign) begin
          nxt_st.neg   = (rx_byte == CH_MINUS);
          nxt_st.phase = PH_SIGNED;
        end else if ((cur_st.phase == PH_BLANKS || cur_st.phase == PH_SIGNED ||
                      cur_st.phase == PH_DIGITS) && digit) begin
          if (|acc_wide[35:32]) begin
            nxt_st.ovf = 1'b1;
          end else begin
            nxt_st.mag = acc_wide[31:0];
          end
          nxt_st.phase = PH_DIGITS;
        end else begin
          nxt_st.phase = PH_BAD;
        end
      end
    end else begin
      // line full: discard it and start over
      nxt_st  = '0;
      nxt_cnt = '0;
    end
  end

endmodule
`default_nettype wire

// ===== src/height_command_line_parser.sv =====
// Height command line parser: takes one byte per cycle, tagged with its serial link,
// and reports one request on the result channel for every newline. Each link keeps
// its own line state (length, parse phase, sign, magnitude) in a small state memory
// with a registered read; nothing of the text itself is stored. A byte is read from
// that memory at the accepting edge, updated in the next cycle and written back, so
// the block takes a new byte every cycle unless stalled, also on the same link, where
// a bypass register hands the just-written state to the following byte. A result is
// registered: its newline passes the update stage and then the result register,
// which holds the result until the result channel takes it. The input stalls
// only while a newline waits behind an unconsumed result. The state memory needs no
// clearing pass after reset: per-link valid bits make untouched entries read as a
// fresh line. Carriage returns and bytes from links beyond NUM_LINKS change nothing.
// Depends on hclp_pkg, hclp_in_if, hclp_out_if and hclp_line_step.
`default_nettype none
module height_command_line_parser #(
  parameter int NUM_LINKS     = hclp_pkg::NUM_LINKS_DEF,
  parameter int LINE_CAPACITY = hclp_pkg::LINE_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hclp_in_if.sink     in_ch,
  hclp_out_if.source  out_ch
);
  import hclp_pkg::*;

  localparam int CW = $clog2(LINE_CAPACITY);
  localparam int AW = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;

  typedef struct packed {
    logic [CW-1:0] cnt;
    line_st_t      st;
  } entry_t;

  // state memory and its per-entry valid bits
  entry_t               mem [NUM_LINKS];
  logic [NUM_LINKS-1:0] ent_vld_r;

  // accept side
  logic          accept;
  logic          in_range;
  logic [AW-1:0] raddr;

  // update stage
  logic          a_vld_r;
  logic [7:0]    a_byte_r;
  logic          a_link_r;
  logic          a_drop_r;
  logic [AW-1:0] a_addr_r;
  entry_t        rd_r;
  logic          rd_vld_r;
  entry_t        byp_r;
  logic          byp_hit_r;
  entry_t        cur;
  entry_t        wdata;
  logic          ignore;
  logic          has_res;
  logic          a_adv;
  logic          we;

  logic               cmd_ok;
  logic signed [31:0] cmd_value;

  logic [1:0] last_src_r;
  logic [1:0] last_src_nxt;

  // result register
  logic               out_vld_r;
  logic               out_ok_r;
  logic signed [31:0] out_value_r;
  logic               out_link_r;
  logic [1:0]         out_src_r;

  assign in_range = (NUM_LINKS > 1) || !in_ch.link_index;
  assign raddr    = in_range ? AW'(in_ch.link_index) : '0;
  assign accept   = in_ch.valid && in_ch.ready;

  // current line state: bypass beats memory, untouched entries are fresh
  always_comb begin
    if (byp_hit_r) begin
      cur = byp_r;
    end else if (rd_vld_r) begin
      cur = rd_r;
    end else begin
      cur = '0;
    end
  end

  hclp_line_step #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_step (
    .cur_st    (cur.st),
    .cur_cnt   (cur.cnt),
    .rx_byte   (a_byte_r),
    .nxt_st    (wdata.st),
    .nxt_cnt   (wdata.cnt),
    .cmd_ok    (cmd_ok),
    .cmd_value (cmd_value)
  );

  assign ignore  = a_drop_r || (a_byte_r == CH_CR);
  assign has_res = a_vld_r && !ignore && (a_byte_r == CH_LF);
  assign a_adv   = !a_vld_r || !has_res || !out_vld_r || out_ch.ready;
  assign we      = a_vld_r && a_adv && !ignore;

  assign in_ch.ready = !a_vld_r || a_adv;

  assign last_src_nxt = cmd_ok ? (2'(a_link_r) + 2'd1) : last_src_r;

  // state memory: one write and one read port, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[a_addr_r] <= wdata;
    end
    if (accept) begin
      rd_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (we) begin
      ent_vld_r[a_addr_r] <= 1'b1;
    end
  end

  // update stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (accept) begin
      a_vld_r <= 1'b1;
    end else if (a_adv) begin
      a_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_byte_r  <= in_ch.rx_byte;
      a_link_r  <= in_ch.link_index;
      a_drop_r  <= !in_range;
      a_addr_r  <= raddr;
      rd_vld_r  <= ent_vld_r[raddr];
      byp_r     <= wdata;
      // same-link write landing at this edge: take it instead of the stale read
      byp_hit_r <= we && (a_addr_r == raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_src_r <= '0;
    end else if (we && has_res) begin
      last_src_r <= last_src_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (has_res && a_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (has_res && a_adv) begin
      out_ok_r    <= cmd_ok;
      out_value_r <= cmd_value;
      out_link_r  <= a_link_r;
      out_src_r   <= last_src_nxt;
    end
  end

  assign out_ch.valid             = out_vld_r;
  assign out_ch.command_valid     = out_ok_r;
  assign out_ch.height_value      = out_value_r;
  assign out_ch.line_link         = out_link_r;
  assign out_ch.last_valid_source = out_src_r;

endmodule
`default_nettype wire
